FILE: rtl/polar_cartesian_vector_converter_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef POLAR_CARTESIAN_VECTOR_CONVERTER_UNIT_DEFINES_SVH
`define POLAR_CARTESIAN_VECTOR_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PCVC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
	else $error("pcvc: same-cycle check failed");

// Next-cycle implication.
`define PCVC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
	else $error("pcvc: next-cycle check failed");

`endif

FILE: rtl/pcvc_pkg.sv
`timescale 1ns / 1ps
package pcvc_pkg;

	localparam int OPND_W      = 32;
	localparam int GUARD_BITS  = 8;
	localparam int VEC_W       = 44;
	localparam int ANGLE_W     = 28;
	localparam int ROOT_W      = 32;
	localparam int SQ_W        = 66;
	localparam int PROD_W      = 62;
	localparam int GAIN_W      = 30;
	localparam int HP_W        = 15;
	localparam int QUO_W       = 10;
	localparam int WRAP_LOW    = 19;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic signed [ANGLE_W-1:0] ANG_QUARTER = 28'sd5898240;
	localparam logic signed [ANGLE_W-1:0] ANG_HALF    = 28'sd11796480;
	localparam logic signed [ANGLE_W-1:0] ANG_FULL    = 28'sd23592960;

	localparam logic signed [15:0] WRAP_OFFSET = 16'sd23040;
	localparam logic [15:0] WRAP_BASE          = 16'd45;
	localparam logic [10:0] WRAP_RECIP         = 11'd1457;
	localparam int WRAP_RECIP_SHIFT            = 16;
	localparam logic [31:0] UNIT_MAG           = 32'd65536;

	typedef enum logic [1:0] {
		CMD_POLAR_TO_CART = 2'd0,
		CMD_CART_TO_POLAR = 2'd1,
		CMD_ROTATE        = 2'd2,
		CMD_NORMALIZE     = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic                     mag_neg;
		logic                     zero_vec;
		logic signed [OPND_W-1:0] first_operand;
		logic signed [OPND_W-1:0] second_operand;
		logic signed [OPND_W-1:0] rotate_angle;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic signed [OPND_W-1:0] first_result;
		logic signed [OPND_W-1:0] second_result;
		logic                     saturated;
	} result_t;

	function automatic logic signed [ANGLE_W-1:0] atan_unit(input int i);
		logic signed [ANGLE_W-1:0] v;
		case (i)
			0:  v = 28'sd2949120;
			1:  v = 28'sd1740967;
			2:  v = 28'sd919879;
			3:  v = 28'sd466945;
			4:  v = 28'sd234379;
			5:  v = 28'sd117304;
			6:  v = 28'sd58666;
			7:  v = 28'sd29335;
			8:  v = 28'sd14668;
			9:  v = 28'sd7334;
			10: v = 28'sd3667;
			11: v = 28'sd1833;
			12: v = 28'sd917;
			13: v = 28'sd458;
			14: v = 28'sd229;
			15: v = 28'sd115;
			16: v = 28'sd57;
			17: v = 28'sd29;
			18: v = 28'sd14;
			19: v = 28'sd7;
			20: v = 28'sd4;
			21: v = 28'sd2;
			22: v = 28'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// CORDIC gain correction in Q30, evaluated at elaboration.
	function automatic logic [63:0] gain_q30(input int steps);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		logic [63:0] quo;
		logic [63:0] rem;
		int i;
		p = 64'd1 << 30;
		for (i = 0; i < steps; i++) begin
			p = p + (p >> (2 * i));
		end
		v = p << 30;
		r = '0;
		bitv = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bitv > v) begin
				bitv = bitv >> 2;
			end
		end
		for (i = 0; i < 32; i++) begin
			if (bitv != '0) begin
				if (v >= r + bitv) begin
					v = v - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		quo = '0;
		rem = '0;
		for (i = 60; i >= 0; i--) begin
			rem = (rem << 1) | (((64'd1 << 60) >> i) & 64'd1);
			if (rem >= r) begin
				rem = rem - r;
				quo = quo | (64'd1 << i);
			end
		end
		return quo;
	endfunction

endpackage

FILE: rtl/pcvc_front.sv
`timescale 1ns / 1ps
module pcvc_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [95:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                queue_full,
	output logic                push,
	output pcvc_pkg::item_t     item
);

	pcvc_pkg::cmd_t cmd;
	logic signed [31:0] opa;
	logic signed [31:0] opb;
	logic signed [31:0] opr;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		cmd = pcvc_pkg::cmd_t'(s_tuser);
		opa = s_tdata[31:0];
		opb = s_tdata[63:32];
		opr = s_tdata[95:64];
		item.cmd            = cmd;
		item.first_operand  = opa;
		item.second_operand = opb;
		item.rotate_angle   = (cmd == pcvc_pkg::CMD_ROTATE) ? opr : '0;
		item.mag_neg        = (cmd == pcvc_pkg::CMD_POLAR_TO_CART) && opa[31];
		item.zero_vec       = (opa == '0) && (opb == '0);
	end

endmodule

FILE: rtl/pcvc_queue.sv
`timescale 1ns / 1ps
module pcvc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pcvc_pkg::item_t        push_item,
	output logic                   full,
	input  logic                   pop,
	output pcvc_pkg::queue_head_t  head
);

	pcvc_pkg::item_t entries_q [pcvc_pkg::QUEUE_DEPTH];
	logic [pcvc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pcvc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pcvc_pkg::QCNT_W-1:0] count_q;

	assign full       = (count_q == pcvc_pkg::QCNT_W'(pcvc_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + pcvc_pkg::QCNT_W'(push) - pcvc_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/pcvc_back.sv
`timescale 1ns / 1ps
`include "polar_cartesian_vector_converter_unit_defines.svh"
module pcvc_back #(
	parameter int DATA_WIDTH   = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   full_circle,
	input  pcvc_pkg::queue_head_t  head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pcvc_pkg::result_t      out_result
);

	localparam int VW        = pcvc_pkg::VEC_W;
	localparam int AW        = pcvc_pkg::ANGLE_W;
	localparam int RW        = pcvc_pkg::ROOT_W;
	localparam int SW        = pcvc_pkg::SQ_W;
	localparam int OUT_BITS  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int STEPS     = CORDIC_STEPS;
	localparam logic [pcvc_pkg::GAIN_W-1:0] GAIN =
		pcvc_pkg::GAIN_W'(pcvc_pkg::gain_q30(STEPS));
	localparam logic signed [VW-1:0] CLIP_HI = VW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] CLIP_LO = -CLIP_HI - VW'(1);
	localparam logic signed [31:0] CLIP_HI32 = 32'(CLIP_HI);
	localparam logic signed [31:0] CLIP_LO32 = 32'(CLIP_LO);
	localparam logic signed [VW-1:0] ROUND_HALF = VW'(1) <<< (pcvc_pkg::GUARD_BITS - 1);

	typedef struct packed {
		pcvc_pkg::cmd_t    cmd;
		logic              mag_neg;
		logic              zero_vec;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] r;
		logic [63:0]       sq_a;
		logic [63:0]       sq_b;
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] z;
	} prep_t;

	typedef struct packed {
		pcvc_pkg::cmd_t    cmd;
		logic              mag_neg;
		logic              zero_vec;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] r;
		logic [SW-1:0]     rem;
		logic [RW-1:0]     root;
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] z;
	} root_t;

	typedef struct packed {
		pcvc_pkg::cmd_t                 cmd;
		logic [RW-1:0]                  root;
		logic [pcvc_pkg::WRAP_LOW-1:0]  low;
		logic [pcvc_pkg::HP_W-1:0]      hp;
		logic [pcvc_pkg::QUO_W-1:0]     quo;
		logic [pcvc_pkg::PROD_W-1:0]    prod;
	} wrap_t;

	typedef struct packed {
		pcvc_pkg::cmd_t    cmd;
		logic [RW-1:0]     root;
		logic signed [31:0] dir;
		logic              neg;
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] a;
	} rot_t;

	function automatic root_t root_step(input root_t s, input int k);
		root_t n;
		logic [SW-1:0] trial;
		int bit_pos;
		n = s;
		bit_pos = RW - 1 - k;
		trial = (SW'(s.root) << (bit_pos + 1)) + (SW'(1) << (2 * bit_pos));
		if (s.rem >= trial) begin
			n.rem  = s.rem - trial;
			n.root = s.root | (RW'(1) << bit_pos);
		end
		if (k < STEPS) begin
			if (!s.y[VW-1]) begin
				n.x = s.x + (s.y >>> k);
				n.y = s.y - (s.x >>> k);
				n.z = s.z + pcvc_pkg::atan_unit(k);
			end else begin
				n.x = s.x - (s.y >>> k);
				n.y = s.y + (s.x >>> k);
				n.z = s.z - pcvc_pkg::atan_unit(k);
			end
		end
		return n;
	endfunction

	function automatic rot_t rot_step(input rot_t s, input int j);
		rot_t n;
		n = s;
		if (!s.a[AW-1]) begin
			n.x = s.x - (s.y >>> j);
			n.y = s.y + (s.x >>> j);
			n.a = s.a - pcvc_pkg::atan_unit(j);
		end else begin
			n.x = s.x + (s.y >>> j);
			n.y = s.y - (s.x >>> j);
			n.a = s.a + pcvc_pkg::atan_unit(j);
		end
		return n;
	endfunction

	function automatic logic signed [VW-1:0] clip(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] c;
		c = v;
		if (v > CLIP_HI) begin
			c = CLIP_HI;
		end else if (v < CLIP_LO) begin
			c = CLIP_LO;
		end
		return c;
	endfunction

	logic adv;
	prep_t prep_d;
	prep_t prep_s1;
	logic  prep_vld_s1;
	root_t root_seed;
	root_t root_s2 [0:RW];
	logic [RW:0] root_vld_s2;
	wrap_t wrap_d;
	wrap_t wrap_s3;
	logic  wrap_vld_s3;
	rot_t  rot_seed;
	rot_t  rot_s4 [0:STEPS];
	logic [STEPS:0] rot_vld_s4;
	pcvc_pkg::result_t res_d;
	pcvc_pkg::result_t result_s5;
	logic  valid_s5;

	logic signed [63:0] sq_a_full;
	logic signed [63:0] sq_b_full;
	logic signed [VW-1:0] ext_a;
	logic signed [VW-1:0] ext_b;
	logic signed [33:0] zsel;
	logic signed [33:0] ang_pre;
	logic signed [33:0] vsum;
	logic signed [15:0] hpos;
	logic [31:0] mag;
	logic [15:0] quo_mul;
	logic [16:0] resid;
	logic [24:0] wrapped;
	logic signed [AW-1:0] ang;
	logic signed [AW-1:0] dir_full;
	logic signed [VW-1:0] nx;
	logic signed [VW-1:0] ny;
	logic signed [VW-1:0] root_ext;

	assign adv        = !valid_s5 || out_ready;
	assign pop        = adv && head.valid;
	assign out_valid  = valid_s5;
	assign out_result = result_s5;

	always_comb begin
		sq_a_full = head.item.first_operand * head.item.first_operand;
		sq_b_full = head.item.second_operand * head.item.second_operand;
		ext_a = VW'(head.item.first_operand) <<< pcvc_pkg::GUARD_BITS;
		ext_b = VW'(head.item.second_operand) <<< pcvc_pkg::GUARD_BITS;
		prep_d.cmd      = head.item.cmd;
		prep_d.mag_neg  = head.item.mag_neg;
		prep_d.zero_vec = head.item.zero_vec;
		prep_d.a        = head.item.first_operand;
		prep_d.b        = head.item.second_operand;
		prep_d.r        = head.item.rotate_angle;
		prep_d.sq_a     = sq_a_full;
		prep_d.sq_b     = sq_b_full;
		if (head.item.first_operand[31]) begin
			prep_d.x = -ext_a;
			prep_d.y = -ext_b;
			prep_d.z = pcvc_pkg::ANG_HALF;
		end else begin
			prep_d.x = ext_a;
			prep_d.y = ext_b;
			prep_d.z = '0;
		end
	end

	always_comb begin
		root_seed.cmd      = prep_s1.cmd;
		root_seed.mag_neg  = prep_s1.mag_neg;
		root_seed.zero_vec = prep_s1.zero_vec;
		root_seed.a        = prep_s1.a;
		root_seed.b        = prep_s1.b;
		root_seed.r        = prep_s1.r;
		root_seed.rem      = SW'(prep_s1.sq_a) + SW'(prep_s1.sq_b);
		root_seed.root     = '0;
		root_seed.x        = prep_s1.x;
		root_seed.y        = prep_s1.y;
		root_seed.z        = prep_s1.z;
	end

	always_comb begin
		zsel = root_s2[RW].zero_vec ? '0 : 34'(root_s2[RW].z);
		case (root_s2[RW].cmd)
			pcvc_pkg::CMD_POLAR_TO_CART: begin
				ang_pre = 34'(root_s2[RW].b) +
					(root_s2[RW].mag_neg ? 34'(pcvc_pkg::ANG_HALF) : 34'sd0);
				mag = root_s2[RW].mag_neg ? 32'(-root_s2[RW].a) : 32'(root_s2[RW].a);
			end
			pcvc_pkg::CMD_ROTATE: begin
				ang_pre = zsel + 34'(root_s2[RW].r);
				mag = root_s2[RW].root;
			end
			pcvc_pkg::CMD_NORMALIZE: begin
				ang_pre = zsel;
				mag = pcvc_pkg::UNIT_MAG;
			end
			default: begin
				ang_pre = zsel;
				mag = root_s2[RW].root;
			end
		endcase
		vsum = ang_pre + 34'(pcvc_pkg::ANG_HALF);
		hpos = 16'(vsum >>> pcvc_pkg::WRAP_LOW) + pcvc_pkg::WRAP_OFFSET;
		wrap_d.cmd  = root_s2[RW].cmd;
		wrap_d.root = root_s2[RW].root;
		wrap_d.low  = vsum[pcvc_pkg::WRAP_LOW-1:0];
		wrap_d.hp   = hpos[pcvc_pkg::HP_W-1:0];
		wrap_d.quo  = pcvc_pkg::QUO_W'((26'(hpos[pcvc_pkg::HP_W-1:0]) *
			26'(pcvc_pkg::WRAP_RECIP)) >> pcvc_pkg::WRAP_RECIP_SHIFT);
		wrap_d.prod = pcvc_pkg::PROD_W'(mag) * pcvc_pkg::PROD_W'(GAIN);
	end

	always_comb begin
		quo_mul = 16'(wrap_s3.quo) * pcvc_pkg::WRAP_BASE;
		resid   = 17'(wrap_s3.hp) - 17'(quo_mul);
		if (resid[16]) begin
			resid = resid + 17'(pcvc_pkg::WRAP_BASE);
		end
		wrapped = {resid[5:0], wrap_s3.low};
		ang = AW'(wrapped) - pcvc_pkg::ANG_HALF;
		dir_full = (full_circle && ang[AW-1]) ? ang + pcvc_pkg::ANG_FULL : ang;
		rot_seed.cmd  = wrap_s3.cmd;
		rot_seed.root = wrap_s3.root;
		rot_seed.dir  = 32'(dir_full);
		rot_seed.x    = VW'(wrap_s3.prod >> (30 - pcvc_pkg::GUARD_BITS));
		rot_seed.y    = '0;
		if (ang > pcvc_pkg::ANG_QUARTER) begin
			rot_seed.a   = ang - pcvc_pkg::ANG_HALF;
			rot_seed.neg = 1'b1;
		end else if (ang < -pcvc_pkg::ANG_QUARTER) begin
			rot_seed.a   = ang + pcvc_pkg::ANG_HALF;
			rot_seed.neg = 1'b1;
		end else begin
			rot_seed.a   = ang;
			rot_seed.neg = 1'b0;
		end
	end

	always_comb begin
		nx = (rot_s4[STEPS].x + ROUND_HALF) >>> pcvc_pkg::GUARD_BITS;
		ny = (rot_s4[STEPS].y + ROUND_HALF) >>> pcvc_pkg::GUARD_BITS;
		if (rot_s4[STEPS].neg) begin
			nx = -nx;
			ny = -ny;
		end
		root_ext = VW'(rot_s4[STEPS].root);
		case (rot_s4[STEPS].cmd)
			pcvc_pkg::CMD_CART_TO_POLAR: begin
				res_d.first_result  = 32'(clip(root_ext));
				res_d.second_result = rot_s4[STEPS].dir;
				res_d.saturated     = (root_ext > CLIP_HI);
			end
			default: begin
				res_d.first_result  = 32'(clip(nx));
				res_d.second_result = 32'(clip(ny));
				res_d.saturated     = (nx > CLIP_HI) || (nx < CLIP_LO) ||
					(ny > CLIP_HI) || (ny < CLIP_LO);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s1 <= 1'b0;
			root_vld_s2 <= '0;
			wrap_vld_s3 <= 1'b0;
			rot_vld_s4  <= '0;
			valid_s5    <= 1'b0;
		end else if (adv) begin
			prep_vld_s1 <= head.valid;
			root_vld_s2 <= {root_vld_s2[RW-1:0], prep_vld_s1};
			wrap_vld_s3 <= root_vld_s2[RW];
			rot_vld_s4  <= {rot_vld_s4[STEPS-1:0], wrap_vld_s3};
			valid_s5    <= rot_vld_s4[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s1    <= prep_d;
			root_s2[0] <= root_seed;
			for (int k = 0; k < RW; k++) begin
				root_s2[k+1] <= root_step(root_s2[k], k);
			end
			wrap_s3    <= wrap_d;
			rot_s4[0]  <= rot_seed;
			for (int j = 0; j < STEPS; j++) begin
				rot_s4[j+1] <= rot_step(rot_s4[j], j);
			end
			result_s5  <= res_d;
		end
	end

	`PCVC_ASSERT_IMPLIES(a_root_remainder, clk, arst_n, root_vld_s2[RW], root_s2[RW].rem <= SW'({root_s2[RW].root, 1'b0}))
	`PCVC_ASSERT_IMPLIES(a_fold_range, clk, arst_n, rot_vld_s4[0], (rot_s4[0].a <= pcvc_pkg::ANG_QUARTER) && (rot_s4[0].a >= -pcvc_pkg::ANG_QUARTER))
	`PCVC_ASSERT_NEXT(a_wrap_advances, clk, arst_n, wrap_vld_s3 && adv, rot_vld_s4[0])
	`PCVC_ASSERT_IMPLIES(a_sat_at_bound, clk, arst_n, valid_s5 && result_s5.saturated, (result_s5.first_result == CLIP_HI32) || (result_s5.first_result == CLIP_LO32) || (result_s5.second_result == CLIP_HI32) || (result_s5.second_result == CLIP_LO32))

endmodule

FILE: rtl/polar_cartesian_vector_converter_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload (lowest bits first)
// s_axis    in   tdata: first_operand, second_operand, rotate_angle; tuser: cmd
// m_axis    out  tdata: first_result, second_result; tuser: saturated
// cfg       in   cfg_wr_data: direction_full_circle
//
// One transaction per cycle in and out while m_tready is high and the queue has room.
// An accepted item reaches m_tvalid through the queue, the prep register, the 33-register
// square-root pipeline, wrap register, rotation CORDIC stages and result register.
// Reset clears the queue, all stage valids and direction_full_circle.
// m_tready low with m_tvalid high freezes the back pipeline; the 4-entry queue fills.
module polar_cartesian_vector_converter_unit #(
	parameter int DATA_WIDTH   = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // first_operand, second_operand, rotate_angle
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // first_result, second_result
	output logic [0:0]  m_tuser,   // saturated
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	logic full_circle_q;
	logic push;
	logic queue_full;
	logic pop;
	pcvc_pkg::item_t       front_item;
	pcvc_pkg::queue_head_t head;
	pcvc_pkg::result_t     result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_circle_q <= 1'b0;
		end else if (cfg_wr_en) begin
			full_circle_q <= cfg_wr_data;
		end
	end

	pcvc_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	pcvc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (pop),
		.head      (head)
	);

	pcvc_back #(
		.DATA_WIDTH   (DATA_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.full_circle (full_circle_q),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (result)
	);

	assign m_tdata = {result.second_result, result.first_result};
	assign m_tuser = result.saturated;

endmodule
